// ----- design/hfui_pkg.sv -----
// shared types, codes and helpers for the hood fan ui mode controller
`timescale 1ns / 1ps

package hfui_pkg;

  localparam int unsigned KEY_TIMER = 0;
  localparam int unsigned KEY_PLUS  = 1;
  localparam int unsigned KEY_MINUS = 2;
  localparam int unsigned KEY_AUTO  = 3;
  localparam int unsigned KEY_LIGHT = 4;

  localparam logic [2:0] RC_TIMER = 3'd1;
  localparam logic [2:0] RC_UP    = 3'd2;
  localparam logic [2:0] RC_DOWN  = 3'd3;
  localparam logic [2:0] RC_AUTO  = 3'd4;
  localparam logic [2:0] RC_ONOFF = 3'd5;
  localparam logic [2:0] RC_LIGHT = 3'd6;

  localparam logic [2:0] MODE_CODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_CODE_AUTO  = 3'd1;
  localparam logic [2:0] MODE_CODE_CLK   = 3'd2;
  localparam logic [2:0] MODE_CODE_BLOW  = 3'd3;
  localparam logic [2:0] MODE_CODE_AOADJ = 3'd4;
  localparam logic [2:0] MODE_CODE_AORUN = 3'd5;

  localparam logic [1:0] BEEP_NONE   = 2'd0;
  localparam logic [1:0] BEEP_SINGLE = 2'd1;
  localparam logic [1:0] BEEP_DOUBLE = 2'd2;

  localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd133;
  localparam logic [4:0] HOUR_MAX           = 5'd23;
  localparam logic [5:0] MINUTE_MAX         = 6'd59;
  localparam logic [3:0] AUTO_OFF_MAX       = 4'd15;
  localparam logic [9:0] SECS_PER_MINUTE    = 10'd60;
  localparam logic [2:0] FAN_MAX            = 3'd4;

  localparam int unsigned ITEM_W   = 40;
  localparam int unsigned RESULT_W = 40;

  typedef enum logic [5:0] {
    MODE_OFF   = 6'b000001,
    MODE_AUTO  = 6'b000010,
    MODE_CLK   = 6'b000100,
    MODE_BLOW  = 6'b001000,
    MODE_AOADJ = 6'b010000,
    MODE_AORUN = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [4:0] key_press;
    logic [4:0] key_down;
    logic [4:0] key_hold;
    logic [4:0] key_release;
    logic [2:0] remote_cmd;
    logic       tick_fast;
    logic       tick_slow;
    logic       auto_off_expired;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] fan_speed;
    logic       edit_stage;
    logic [4:0] edit_hour;
    logic [5:0] edit_minute;
    logic [3:0] auto_off_minutes;
    logic [9:0] auto_off_seconds;
    logic       clock_write;
    logic [1:0] beep;
    logic       light_on;
    logic       backlight_on;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_OFF:   c = MODE_CODE_OFF;
      MODE_AUTO:  c = MODE_CODE_AUTO;
      MODE_CLK:   c = MODE_CODE_CLK;
      MODE_BLOW:  c = MODE_CODE_BLOW;
      MODE_AOADJ: c = MODE_CODE_AOADJ;
      MODE_AORUN: c = MODE_CODE_AORUN;
      default:    c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

// ----- design/hfui_ctrl.sv -----
// mode controller state registers and per-request decision logic
`timescale 1ns / 1ps

module hfui_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  hfui_pkg::item_t     item,
  input  logic [7:0]          idle_timeout,
  output hfui_pkg::result_t   res
);

  hfui_pkg::mode_t mode_reg, mode_reg_next;
  logic [2:0] fan_reg, fan_reg_next;
  logic       stage_reg, stage_reg_next;
  logic [4:0] hour_reg, hour_reg_next;
  logic [5:0] minute_reg, minute_reg_next;
  logic [3:0] auto_off_reg, auto_off_reg_next;
  logic [7:0] idle_count, idle_count_next;
  logic       fast_flag, fast_flag_next;
  logic       slow_flag, slow_flag_next;
  logic       light_reg, light_reg_next;

  always_comb begin
    logic timer_k, plus_k, minus_k, auto_k, light_k, busy, up, dn, wr;
    logic [8:0] cnt;
    logic [9:0] secs;
    logic [1:0] beep;
    logic [4:0] wr_h;
    logic [5:0] wr_m;

    timer_k = item.key_press[hfui_pkg::KEY_TIMER] || item.remote_cmd == hfui_pkg::RC_TIMER;
    plus_k  = item.key_press[hfui_pkg::KEY_PLUS] || item.remote_cmd == hfui_pkg::RC_UP;
    minus_k = item.key_press[hfui_pkg::KEY_MINUS] || item.remote_cmd == hfui_pkg::RC_DOWN;
    auto_k  = item.key_press[hfui_pkg::KEY_AUTO] || item.remote_cmd == hfui_pkg::RC_AUTO
              || item.remote_cmd == hfui_pkg::RC_ONOFF;
    light_k = item.key_press[hfui_pkg::KEY_LIGHT] || item.remote_cmd == hfui_pkg::RC_LIGHT;
    busy    = item.key_down[hfui_pkg::KEY_PLUS] || item.key_down[hfui_pkg::KEY_MINUS]
              || item.key_down[hfui_pkg::KEY_LIGHT] || light_k;

    mode_reg_next     = mode_reg;
    fan_reg_next      = fan_reg;
    stage_reg_next    = stage_reg;
    hour_reg_next     = hour_reg;
    minute_reg_next   = minute_reg;
    auto_off_reg_next = auto_off_reg;
    fast_flag_next    = fast_flag | item.tick_fast;
    slow_flag_next    = slow_flag | item.tick_slow;
    cnt  = {1'b0, idle_count};
    secs = '0;
    beep = hfui_pkg::BEEP_NONE;
    wr   = 1'b0;
    wr_h = '0;
    wr_m = '0;
    up   = 1'b0;
    dn   = 1'b0;

    case (mode_reg)
      hfui_pkg::MODE_OFF: begin
        if (timer_k) begin
          hour_reg_next   = item.clock_hour;
          minute_reg_next = item.clock_minute;
          stage_reg_next  = 1'b0;
          mode_reg_next   = hfui_pkg::MODE_CLK;
          cnt = '0;
        end
        if (plus_k) begin
          fan_reg_next  = 3'd1;
          mode_reg_next = hfui_pkg::MODE_BLOW;
        end
        if (minus_k) begin
          fan_reg_next  = hfui_pkg::FAN_MAX;
          mode_reg_next = hfui_pkg::MODE_BLOW;
        end
        if (auto_k) mode_reg_next = hfui_pkg::MODE_AUTO;
      end
      hfui_pkg::MODE_AUTO: begin
        if (auto_k) mode_reg_next = hfui_pkg::MODE_OFF;
      end
      hfui_pkg::MODE_CLK: begin
        cnt = cnt + 9'd1;
        up = plus_k || (item.key_hold[hfui_pkg::KEY_PLUS] && fast_flag_next);
        if (timer_k || cnt > {1'b0, idle_timeout}) begin
          if (!stage_reg) begin
            stage_reg_next = 1'b1;
            cnt = '0;
            if (!item.key_press[hfui_pkg::KEY_TIMER]) beep = hfui_pkg::BEEP_SINGLE;
          end else begin
            wr   = 1'b1;
            wr_h = hour_reg;
            wr_m = minute_reg;
            mode_reg_next = hfui_pkg::MODE_OFF;
            beep = hfui_pkg::BEEP_DOUBLE;
          end
        end
        if (up) begin
          fast_flag_next = 1'b0;
          cnt = '0;
          if (!stage_reg)
            hour_reg_next = (hour_reg >= hfui_pkg::HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
          else
            minute_reg_next = (minute_reg >= hfui_pkg::MINUTE_MAX) ? 6'd0
                              : minute_reg + 6'd1;
        end
        dn = minus_k || (item.key_hold[hfui_pkg::KEY_MINUS] && fast_flag_next);
        if (dn) begin
          fast_flag_next = 1'b0;
          cnt = '0;
          if (!stage_reg)
            hour_reg_next = (hour_reg_next == 5'd0 || hour_reg_next > hfui_pkg::HOUR_MAX)
                            ? hfui_pkg::HOUR_MAX : hour_reg_next - 5'd1;
          else
            minute_reg_next = (minute_reg_next == 6'd0
                               || minute_reg_next > hfui_pkg::MINUTE_MAX)
                              ? hfui_pkg::MINUTE_MAX : minute_reg_next - 6'd1;
        end
        if (busy) cnt = '0;
      end
      hfui_pkg::MODE_BLOW, hfui_pkg::MODE_AORUN: begin
        if (plus_k) begin
          if (fan_reg_next >= hfui_pkg::FAN_MAX) begin
            fan_reg_next  = 3'd0;
            mode_reg_next = hfui_pkg::MODE_OFF;
          end else begin
            fan_reg_next = fan_reg_next + 3'd1;
          end
        end
        if (minus_k) begin
          if (fan_reg_next <= 3'd1) begin
            fan_reg_next  = 3'd0;
            mode_reg_next = hfui_pkg::MODE_OFF;
          end else begin
            fan_reg_next = fan_reg_next - 3'd1;
          end
        end
        if (auto_k) begin
          fan_reg_next  = 3'd0;
          mode_reg_next = hfui_pkg::MODE_AUTO;
        end
        if (mode_reg == hfui_pkg::MODE_BLOW) begin
          if (timer_k) begin
            auto_off_reg_next = 4'd1;
            mode_reg_next = hfui_pkg::MODE_AOADJ;
            cnt = '0;
          end
        end else begin
          if ((item.key_release[hfui_pkg::KEY_TIMER] && !item.key_hold[hfui_pkg::KEY_TIMER])
              || item.remote_cmd == hfui_pkg::RC_TIMER)
            mode_reg_next = hfui_pkg::MODE_BLOW;
          if (item.auto_off_expired) begin
            fan_reg_next  = 3'd0;
            mode_reg_next = hfui_pkg::MODE_OFF;
            beep = hfui_pkg::BEEP_SINGLE;
          end
        end
      end
      hfui_pkg::MODE_AOADJ: begin
        cnt = cnt + 9'd1;
        up = plus_k || (item.key_hold[hfui_pkg::KEY_PLUS] && slow_flag_next);
        if (up) begin
          slow_flag_next = 1'b0;
          cnt = '0;
          auto_off_reg_next = (auto_off_reg >= hfui_pkg::AUTO_OFF_MAX) ? 4'd1
                              : auto_off_reg + 4'd1;
        end
        dn = minus_k || (item.key_hold[hfui_pkg::KEY_MINUS] && slow_flag_next);
        if (dn) begin
          slow_flag_next = 1'b0;
          cnt = '0;
          auto_off_reg_next = (auto_off_reg_next <= 4'd1) ? hfui_pkg::AUTO_OFF_MAX
                              : auto_off_reg_next - 4'd1;
        end
        if (timer_k) mode_reg_next = hfui_pkg::MODE_BLOW;
        if (busy) cnt = '0;
        if (cnt > {1'b0, idle_timeout}) begin
          mode_reg_next = hfui_pkg::MODE_AORUN;
          secs = 10'({6'd0, auto_off_reg_next} * hfui_pkg::SECS_PER_MINUTE);
          beep = hfui_pkg::BEEP_DOUBLE;
        end
      end
      default: begin
      end
    endcase

    idle_count_next = cnt[8] ? 8'hFF : cnt[7:0];
    light_reg_next  = light_reg ^ light_k;

    res.mode             = hfui_pkg::mode_code(mode_reg_next);
    res.fan_speed        = fan_reg_next;
    res.edit_stage       = stage_reg_next;
    res.edit_hour        = wr ? wr_h : hour_reg_next;
    res.edit_minute      = wr ? wr_m : minute_reg_next;
    res.auto_off_minutes = auto_off_reg_next;
    res.auto_off_seconds = secs;
    res.clock_write      = wr;
    res.beep             = beep;
    res.light_on         = light_reg_next;
    res.backlight_on     = !(mode_reg_next == hfui_pkg::MODE_OFF && !light_reg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= hfui_pkg::MODE_OFF;
      fan_reg      <= '0;
      stage_reg    <= 1'b0;
      hour_reg     <= '0;
      minute_reg   <= '0;
      auto_off_reg <= 4'd1;
      idle_count   <= '0;
      fast_flag    <= 1'b0;
      slow_flag    <= 1'b0;
      light_reg    <= 1'b0;
    end else if (adv) begin
      mode_reg     <= mode_reg_next;
      fan_reg      <= fan_reg_next;
      stage_reg    <= stage_reg_next;
      hour_reg     <= hour_reg_next;
      minute_reg   <= minute_reg_next;
      auto_off_reg <= auto_off_reg_next;
      idle_count   <= idle_count_next;
      fast_flag    <= fast_flag_next;
      slow_flag    <= slow_flag_next;
      light_reg    <= light_reg_next;
    end
  end

endmodule

// ----- design/hood_fan_ui_mode_controller_unit.sv -----
// an accepted request is held in the input register, then its result in the result register
// throughput: one request per cycle; the input register, decision logic and result register
// form a single pass, and a stalled result holds one request in the input register and
// blocks the next until the result is taken
// reset: synchronous rst clears mode to off, fan, edit values, idle count, repeat flags and lamp,
// sets auto-off minutes to 1 and idle_timeout to 133; no clearing pass is needed
`timescale 1ns / 1ps

module hood_fan_ui_mode_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // key_press, key_down, key_hold, key_release, remote_cmd, tick_fast, tick_slow,
  // auto_off_expired, clock_hour, clock_minute, zero fill
  input  logic [hfui_pkg::ITEM_W-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // mode, fan_speed, edit_stage, edit_hour, edit_minute, auto_off_minutes,
  // auto_off_seconds, clock_write, beep, light_on, backlight_on, zero fill
  output logic [hfui_pkg::RESULT_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_data
);

  logic              in_valid;
  hfui_pkg::item_t   in_item;
  logic              adv;
  logic [7:0]        idle_timeout;
  hfui_pkg::result_t res;
  hfui_pkg::result_t out_res;

  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      idle_timeout <= hfui_pkg::IDLE_TIMEOUT_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_valid) idle_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.key_press        <= s_tdata[4:0];
      in_item.key_down         <= s_tdata[9:5];
      in_item.key_hold         <= s_tdata[14:10];
      in_item.key_release      <= s_tdata[19:15];
      in_item.remote_cmd       <= s_tdata[22:20];
      in_item.tick_fast        <= s_tdata[23];
      in_item.tick_slow        <= s_tdata[24];
      in_item.auto_off_expired <= s_tdata[25];
      in_item.clock_hour       <= s_tdata[30:26];
      in_item.clock_minute     <= s_tdata[36:31];
    end
    if (adv) out_res <= res;
  end

  hfui_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .item         (in_item),
    .idle_timeout (idle_timeout),
    .res          (res)
  );

  assign m_tdata = {3'd0,
                    out_res.backlight_on,
                    out_res.light_on,
                    out_res.beep,
                    out_res.clock_write,
                    out_res.auto_off_seconds,
                    out_res.auto_off_minutes,
                    out_res.edit_minute,
                    out_res.edit_hour,
                    out_res.edit_stage,
                    out_res.fan_speed,
                    out_res.mode};

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("result or input register valid after reset");

  a_write_commits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[2:0] == hfui_pkg::MODE_CODE_OFF
                               && m_tdata[34:33] == hfui_pkg::BEEP_DOUBLE)
    else $error("clock write without return to off and double beep");

  a_secs_on_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:22] != 10'd0 |-> m_tdata[2:0] == hfui_pkg::MODE_CODE_AORUN
                                           && m_tdata[34:33] == hfui_pkg::BEEP_DOUBLE)
    else $error("auto-off load outside the start of auto-off");

  a_single_beep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34:33] == hfui_pkg::BEEP_SINGLE
    |-> m_tdata[2:0] == hfui_pkg::MODE_CODE_CLK || m_tdata[2:0] == hfui_pkg::MODE_CODE_OFF)
    else $error("single beep in unexpected mode");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid && $stable(in_item))
    else $error("pending request lost while result stalled");
`endif

endmodule

// ----- dv/tb_hood_fan_ui_mode_controller_unit.sv -----
// self-checking testbench for the hood fan ui mode controller unit
`timescale 1ns / 1ps

module tb_hood_fan_ui_mode_controller_unit;
  import hfui_pkg::*;

  class fan_ui_scoreboard;
    logic [7:0] idle_limit;
    logic [2:0] mode_r;
    logic [2:0] fan_r;
    logic       stage_r;
    logic [4:0] hour_r;
    logic [5:0] minute_r;
    logic [3:0] delay_min;
    int         idle_cnt;
    bit         fast_flag;
    bit         slow_flag;
    bit         lamp;
    result_t    pending[$];
    int         errors;
    int         checked;
    int         n_commits;
    int         n_auto_off;

    function new();
      idle_limit = IDLE_TIMEOUT_RESET;
      mode_r     = MODE_CODE_OFF;
      fan_r      = '0;
      stage_r    = 1'b0;
      hour_r     = '0;
      minute_r   = '0;
      delay_min  = 4'd1;
      idle_cnt   = 0;
      fast_flag  = 1'b0;
      slow_flag  = 1'b0;
      lamp       = 1'b0;
      errors     = 0;
      checked    = 0;
      n_commits  = 0;
      n_auto_off = 0;
    endfunction

    function void set_idle_limit(logic [7:0] v);
      idle_limit = v;
    endfunction

    function void step_speed(bit up, bit dn);
      if (up) begin
        if (fan_r >= FAN_MAX) begin
          fan_r  = '0;
          mode_r = MODE_CODE_OFF;
        end else begin
          fan_r = fan_r + 3'd1;
        end
      end
      if (dn) begin
        if (fan_r <= 3'd1) begin
          fan_r  = '0;
          mode_r = MODE_CODE_OFF;
        end else begin
          fan_r = fan_r - 3'd1;
        end
      end
    endfunction

    function void note_request(item_t it);
      result_t    e;
      int         cnt;
      bit         timer_k, plus_k, minus_k, auto_k, light_k, busy, up, dn, wr;
      logic [4:0] wr_h;
      logic [5:0] wr_m;
      logic [9:0] secs;
      logic [1:0] beep;
      cnt     = idle_cnt;
      wr      = 1'b0;
      wr_h    = '0;
      wr_m    = '0;
      secs    = '0;
      beep    = BEEP_NONE;
      timer_k = it.key_press[KEY_TIMER] || it.remote_cmd == RC_TIMER;
      plus_k  = it.key_press[KEY_PLUS] || it.remote_cmd == RC_UP;
      minus_k = it.key_press[KEY_MINUS] || it.remote_cmd == RC_DOWN;
      auto_k  = it.key_press[KEY_AUTO] || it.remote_cmd == RC_AUTO || it.remote_cmd == RC_ONOFF;
      light_k = it.key_press[KEY_LIGHT] || it.remote_cmd == RC_LIGHT;
      busy    = it.key_down[KEY_PLUS] || it.key_down[KEY_MINUS] || it.key_down[KEY_LIGHT] ||
                light_k;
      if (it.tick_fast) fast_flag = 1'b1;
      if (it.tick_slow) slow_flag = 1'b1;

      case (mode_r)
        MODE_CODE_OFF: begin
          if (timer_k) begin
            hour_r   = it.clock_hour;
            minute_r = it.clock_minute;
            stage_r  = 1'b0;
            mode_r   = MODE_CODE_CLK;
            cnt      = 0;
          end
          if (plus_k) begin
            fan_r  = 3'd1;
            mode_r = MODE_CODE_BLOW;
          end
          if (minus_k) begin
            fan_r  = FAN_MAX;
            mode_r = MODE_CODE_BLOW;
          end
          if (auto_k) mode_r = MODE_CODE_AUTO;
        end
        MODE_CODE_AUTO: begin
          if (auto_k) mode_r = MODE_CODE_OFF;
        end
        MODE_CODE_CLK: begin
          cnt++;
          up = plus_k || (it.key_hold[KEY_PLUS] && fast_flag);
          if (!stage_r) begin
            if (timer_k || cnt > idle_limit) begin
              stage_r = 1'b1;
              cnt     = 0;
              if (!it.key_press[KEY_TIMER]) beep = BEEP_SINGLE;
            end
            if (up) begin
              fast_flag = 1'b0;
              cnt       = 0;
              hour_r    = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
            end
            dn = minus_k || (it.key_hold[KEY_MINUS] && fast_flag);
            if (dn) begin
              fast_flag = 1'b0;
              cnt       = 0;
              hour_r    = (hour_r == 5'd0 || hour_r > HOUR_MAX) ? HOUR_MAX : hour_r - 5'd1;
            end
          end else begin
            if (timer_k || cnt > idle_limit) begin
              wr     = 1'b1;
              wr_h   = hour_r;
              wr_m   = minute_r;
              mode_r = MODE_CODE_OFF;
              beep   = BEEP_DOUBLE;
            end
            if (up) begin
              fast_flag = 1'b0;
              cnt       = 0;
              minute_r  = (minute_r >= MINUTE_MAX) ? 6'd0 : minute_r + 6'd1;
            end
            dn = minus_k || (it.key_hold[KEY_MINUS] && fast_flag);
            if (dn) begin
              fast_flag = 1'b0;
              cnt       = 0;
              minute_r  = (minute_r == 6'd0 || minute_r > MINUTE_MAX) ? MINUTE_MAX :
                          minute_r - 6'd1;
            end
          end
          if (busy) cnt = 0;
        end
        MODE_CODE_BLOW: begin
          step_speed(plus_k, minus_k);
          if (auto_k) begin
            fan_r  = '0;
            mode_r = MODE_CODE_AUTO;
          end
          if (timer_k) begin
            delay_min = 4'd1;
            mode_r    = MODE_CODE_AOADJ;
            cnt       = 0;
          end
        end
        MODE_CODE_AOADJ: begin
          cnt++;
          up = plus_k || (it.key_hold[KEY_PLUS] && slow_flag);
          if (up) begin
            slow_flag = 1'b0;
            cnt       = 0;
            delay_min = (delay_min >= AUTO_OFF_MAX) ? 4'd1 : delay_min + 4'd1;
          end
          dn = minus_k || (it.key_hold[KEY_MINUS] && slow_flag);
          if (dn) begin
            slow_flag = 1'b0;
            cnt       = 0;
            delay_min = (delay_min <= 4'd1) ? AUTO_OFF_MAX : delay_min - 4'd1;
          end
          if (timer_k) mode_r = MODE_CODE_BLOW;
          if (busy) cnt = 0;
          if (cnt > idle_limit) begin
            mode_r = MODE_CODE_AORUN;
            secs   = delay_min * SECS_PER_MINUTE;
            beep   = BEEP_DOUBLE;
            n_auto_off++;
          end
        end
        MODE_CODE_AORUN: begin
          step_speed(plus_k, minus_k);
          if (auto_k) begin
            fan_r  = '0;
            mode_r = MODE_CODE_AUTO;
          end
          if ((it.key_release[KEY_TIMER] && !it.key_hold[KEY_TIMER]) ||
              it.remote_cmd == RC_TIMER)
            mode_r = MODE_CODE_BLOW;
          if (it.auto_off_expired) begin
            fan_r  = '0;
            mode_r = MODE_CODE_OFF;
            beep   = BEEP_SINGLE;
          end
        end
        default: begin
        end
      endcase

      idle_cnt = (cnt > 255) ? 255 : cnt;
      if (light_k) lamp = ~lamp;
      if (wr) n_commits++;

      e.mode             = mode_r;
      e.fan_speed        = fan_r;
      e.edit_stage       = stage_r;
      e.edit_hour        = wr ? wr_h : hour_r;
      e.edit_minute      = wr ? wr_m : minute_r;
      e.auto_off_minutes = delay_min;
      e.auto_off_seconds = secs;
      e.clock_write      = wr;
      e.beep             = beep;
      e.light_on         = lamp;
      e.backlight_on     = !(mode_r == MODE_CODE_OFF && !lamp);
      pending.push_back(e);
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [RESULT_W-1:0] d);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("mode", e.mode, d[2:0]);
      cmp("fan_speed", e.fan_speed, d[5:3]);
      cmp("edit_stage", e.edit_stage, d[6]);
      cmp("edit_hour", e.edit_hour, d[11:7]);
      cmp("edit_minute", e.edit_minute, d[17:12]);
      cmp("auto_off_minutes", e.auto_off_minutes, d[21:18]);
      cmp("auto_off_seconds", e.auto_off_seconds, d[31:22]);
      cmp("clock_write", e.clock_write, d[32]);
      cmp("beep", e.beep, d[34:33]);
      cmp("light_on", e.light_on, d[35]);
      cmp("backlight_on", e.backlight_on, d[36]);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ITEM_W-1:0]   s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = 8'd0;

  fan_ui_scoreboard sb;
  int tx_idle_pct = 10;
  int rx_idle_pct = 69;
  int quiet_left = 0;
  int n_sent = 0;

  hood_fan_ui_mode_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic logic [ITEM_W-1:0] pack_item(item_t it);
    return {3'b000, it.clock_minute, it.clock_hour, it.auto_off_expired, it.tick_slow,
            it.tick_fast, it.remote_cmd, it.key_release, it.key_hold, it.key_down,
            it.key_press};
  endfunction

  function automatic item_t mk(logic [4:0] press, logic [4:0] down, logic [4:0] hold,
                               logic [4:0] rel, logic [2:0] rc, int tf, int ts, int ex,
                               logic [4:0] hr, logic [5:0] mn);
    item_t it;
    it.key_press        = press;
    it.key_down         = down;
    it.key_hold         = hold;
    it.key_release      = rel;
    it.remote_cmd       = rc;
    it.tick_fast        = tf[0];
    it.tick_slow        = ts[0];
    it.auto_off_expired = ex[0];
    it.clock_hour       = hr;
    it.clock_minute     = mn;
    return it;
  endfunction

  function automatic item_t gen_request();
    item_t it;
    it = '0;
    it.key_release  = 5'($urandom);
    it.tick_fast    = 1'($urandom_range(0, 1));
    it.tick_slow    = 1'($urandom_range(0, 1));
    it.clock_hour   = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
                                                      : $urandom_range(0, 23));
    it.clock_minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
                                                      : $urandom_range(0, 59));
    if (sb.mode_r != MODE_CODE_CLK && sb.mode_r != MODE_CODE_AOADJ) quiet_left = 0;
    if (quiet_left > 0) begin
      quiet_left--;
      return it;
    end
    if ($urandom_range(0, 99) < 12) begin
      it.key_press        = 5'($urandom);
      it.key_down         = 5'($urandom);
      it.key_hold         = 5'($urandom);
      it.remote_cmd       = 3'($urandom_range(0, 7));
      it.auto_off_expired = 1'($urandom_range(0, 1));
      return it;
    end
    case (sb.mode_r)
      MODE_CODE_OFF: begin
        case ($urandom_range(0, 6))
          0: it.key_press[KEY_TIMER] = 1'b1;
          1: it.remote_cmd = RC_TIMER;
          2: it.key_press[KEY_PLUS] = 1'b1;
          3: it.remote_cmd = RC_DOWN;
          4: it.key_press[KEY_AUTO] = 1'b1;
          5: it.key_press[KEY_LIGHT] = 1'b1;
          default: begin
          end
        endcase
      end
      MODE_CODE_AUTO: begin
        case ($urandom_range(0, 3))
          0: it.key_press[KEY_AUTO] = 1'b1;
          1: it.remote_cmd = RC_ONOFF;
          2: it.remote_cmd = RC_LIGHT;
          default: begin
          end
        endcase
      end
      MODE_CODE_CLK, MODE_CODE_AOADJ: begin
        case ($urandom_range(0, 9))
          0, 1: quiet_left = 2 * int'(sb.idle_limit) + 4;
          2: it.key_press[KEY_PLUS] = 1'b1;
          3: it.remote_cmd = RC_DOWN;
          4: it.key_hold[KEY_PLUS] = 1'b1;
          5: it.key_hold[KEY_MINUS] = 1'b1;
          6: it.key_press[KEY_TIMER] = 1'b1;
          7: it.remote_cmd = RC_TIMER;
          8: it.key_down = 5'($urandom);
          default: begin
          end
        endcase
      end
      MODE_CODE_BLOW: begin
        case ($urandom_range(0, 7))
          0: it.key_press[KEY_PLUS] = 1'b1;
          1: it.key_press[KEY_MINUS] = 1'b1;
          2: it.remote_cmd = RC_UP;
          3: it.remote_cmd = RC_DOWN;
          4, 5: it.key_press[KEY_TIMER] = 1'b1;
          6: it.key_press[KEY_AUTO] = 1'b1;
          default: begin
          end
        endcase
      end
      MODE_CODE_AORUN: begin
        it.key_release = '0;
        case ($urandom_range(0, 9))
          0: it.key_press[KEY_PLUS] = 1'b1;
          1: it.key_press[KEY_MINUS] = 1'b1;
          2: begin
            it.key_release[KEY_TIMER] = 1'b1;
            it.key_hold[KEY_TIMER]    = 1'($urandom_range(0, 1));
          end
          3: it.remote_cmd = RC_TIMER;
          4: it.auto_off_expired = 1'b1;
          5: it.remote_cmd = RC_AUTO;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    return it;
  endfunction

  task automatic send_request(item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle_limit(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_idle_limit(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) send_request(gen_request());
  endtask

  initial begin
    item_t directed[$];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timeout, walk through off, auto, clock edit, blow and auto-off adjust and the wrap cases
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_LIGHT, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, RC_LIGHT, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, 3'd7, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_AUTO, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, RC_ONOFF, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_TIMER, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, HOUR_MAX,
                          MINUTE_MAX));
    directed.push_back(mk(5'd1 << KEY_PLUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_MINUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd1 << KEY_PLUS, 5'd0, 3'd0, 1, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd1 << KEY_PLUS, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, RC_TIMER, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_PLUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_MINUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    // commit and minute step in the same pass
    directed.push_back(mk((5'd1 << KEY_TIMER) | (5'd1 << KEY_PLUS), 5'd0, 5'd0, 5'd0, 3'd0,
                          0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_PLUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, RC_UP, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd0, 5'd0, RC_UP, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_PLUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_PLUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_MINUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_TIMER, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_MINUS, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd0, 5'd0, 5'd1 << KEY_PLUS, 5'd0, 3'd0, 0, 1, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'd1 << KEY_TIMER, 5'd0, 5'd0, 5'd0, 3'd0, 0, 0, 0, 5'd0, 6'd0));
    directed.push_back(mk(5'h1f, 5'h1f, 5'h1f, 5'h1f, 3'd7, 1, 1, 1, 5'h1f, 6'h3f));
    foreach (directed[i]) send_request(directed[i]);
    wait_drained();

    write_idle_limit(8'd3);
    run_random(300);
    wait_drained();

    tx_idle_pct = 69;
    rx_idle_pct = 10;
    write_idle_limit(8'd255);
    run_random(400);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_idle_limit(8'd1);
    run_random(150);
    wait_drained();

    write_idle_limit(8'($urandom_range(2, 40)));
    run_random(200);
    wait_drained();

    $display("summary: %0d requests sent, %0d results checked, timeouts 133/3/255/1/random",
             n_sent, sb.checked);
    $display("summary: %0d clock writes, %0d auto-off starts seen", sb.n_commits,
             sb.n_auto_off);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
